// File: sv/trie_word_break_prefix_core_defines.svh
// Assertion macros shared by the trie word-break RTL.
`ifndef TRIE_WORD_BREAK_PREFIX_CORE_DEFINES_SVH
`define TRIE_WORD_BREAK_PREFIX_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define TWB_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("twb assertion failed");
`define TWB_ASSERT_NEVER(name, expr) \
  `TWB_ASSERT(name, !(expr))
`else
`define TWB_ASSERT(name, prop)
`define TWB_ASSERT_NEVER(name, expr)
`endif
`endif

// File: sv/twb_pkg.sv
// Package with the fixed field widths, codes and control structs of the trie word-break core.
`timescale 1ns / 1ps
package twb_pkg;
  localparam int LETTER_W = 5;
  localparam int KIND_W   = 2;
  localparam int ANSWER_W = 21;

  localparam logic [KIND_W-1:0] KIND_ANSWER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STORED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FULL   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_LONG   = 2'd3;

  localparam logic [1:0] BAD_NONE = 2'd0;
  localparam logic [1:0] BAD_FULL = 2'd1;
  localparam logic [1:0] BAD_LONG = 2'd2;

  localparam logic OP_WORD = 1'b0;
  localparam logic OP_TEXT = 1'b1;

  typedef struct packed {
    logic                start;
    logic                op;
    logic [LETTER_W-1:0] letter;
    logic                last;
    logic                res_ready;
  } twb_cmd_t;

  typedef struct packed {
    logic                ready;
    logic                res_valid;
    logic [KIND_W-1:0]   kind;
    logic [ANSWER_W-1:0] answer;
  } twb_stat_t;
endpackage

// File: sv/twb_if.sv
// Valid/ready channel interfaces for letters in and results out.
`timescale 1ns / 1ps
interface twb_in_if;
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [twb_pkg::LETTER_W-1:0] letter;
  logic                         last;
  modport source (output valid, output operation, output letter, output last, input ready);
  modport sink (input valid, input operation, input letter, input last, output ready);
endinterface

interface twb_out_if;
  logic                         valid;
  logic                         ready;
  logic [twb_pkg::KIND_W-1:0]   kind;
  logic [twb_pkg::ANSWER_W-1:0] answer;
  modport source (output valid, output kind, output answer, input ready);
  modport sink (input valid, input kind, input answer, output ready);
endinterface

// File: sv/twb_mem.sv
// Single-port-write, registered-read memory holding the trie child table.
`timescale 1ns / 1ps
module twb_mem #(
  parameter int DEPTH = 13312,
  parameter int WIDTH = 10,
  parameter int AW    = 14
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

// File: sv/twb_seq.sv
// Sequencer: trie insert, walk advance over slots, clearing sweep and result build.
`timescale 1ns / 1ps
`include "trie_word_break_prefix_core_defines.svh"
module twb_seq #(
  parameter int TRIE_NODES = 512,
  parameter int MAX_WORD   = 16,
  parameter int ALPHABET   = 26,
  parameter int POS_BITS   = 21
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  twb_pkg::twb_cmd_t  cmd_i,
  output twb_pkg::twb_stat_t stat_o
);
  localparam int NW    = $clog2(TRIE_NODES);
  localparam int DEPTH = TRIE_NODES * ALPHABET;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(TRIE_NODES + 1);
  localparam int LENW  = $clog2(MAX_WORD + 1);
  localparam int SW    = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
  localparam int MW    = NW + 1;
  localparam logic [POS_BITS-1:0] POS_LIMIT = '1;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DISS  = 3'd2;
  localparam logic [2:0] S_DWR   = 3'd3;
  localparam logic [2:0] S_QRUN  = 3'd4;
  localparam logic [2:0] S_QLAST = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]                     state_q, state_d;
  logic [AW-1:0]                  clr_q, clr_d;
  logic [twb_pkg::LETTER_W-1:0]   letter_q, letter_d;
  logic                           last_q, last_d;
  logic [AW-1:0]                  addr_q, addr_d;
  logic [CW-1:0]                  count_q, count_d;
  logic [NW-1:0]                  cursor_q, cursor_d;
  logic [LENW-1:0]                len_q, len_d;
  logic [1:0]                     bad_q, bad_d;
  logic [NW-1:0]                  walk_node_q [MAX_WORD];
  logic [NW-1:0]                  walk_node_d [MAX_WORD];
  logic [MAX_WORD-1:0]            walk_valid_q, walk_valid_d;
  logic [POS_BITS-1:0]            pos_q, pos_d;
  logic [POS_BITS-1:0]            best_q, best_d;
  logic                           hit_q, hit_d;
  logic [SW-1:0]                  slot_q, slot_d;
  logic                           pend_q, pend_d;
  logic                           rdv_q, rdv_d;
  logic [SW-1:0]                  pslot_q, pslot_d;
  logic [twb_pkg::KIND_W-1:0]     kind_q, kind_d;
  logic [twb_pkg::ANSWER_W-1:0]   answer_q, answer_d;

  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_waddr, rd_addr;
  logic [MW-1:0]       mem_wdata, mem_rdata;
  logic [NW-1:0]       mul_node, child;
  logic                term, pend_hit, hit_now, nx_ok;
  logic [SW-1:0]       nx_slot;
  logic [POS_BITS-1:0] pos_inc;
  logic [1:0]          fin_bad;
  logic [NW-1:0]       ins_nxt;

  twb_mem #(.DEPTH(DEPTH), .WIDTH(MW), .AW(AW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (rd_addr),
    .rdata_o (mem_rdata)
  );

  // form the child-table address from the node in use and the letter
  assign mul_node = (state_q == S_QRUN) ? walk_node_q[slot_q] : cursor_q;
  assign rd_addr  = AW'(mul_node) * AW'(ALPHABET) + AW'(letter_q);
  assign child    = mem_rdata[NW-1:0];
  assign term     = mem_rdata[NW];

  // decode the walk read that returned this cycle
  assign pend_hit = pend_q && rdv_q && (child != '0) && term;
  assign hit_now  = hit_q | pend_hit;
  assign nx_ok    = (int'(pslot_q) + 1) < MAX_WORD;
  assign nx_slot  = SW'({1'b0, pslot_q} + (SW + 1)'(1));
  assign pos_inc  = (pos_q < POS_LIMIT) ? pos_q + POS_BITS'(1) : pos_q;

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    letter_d     = letter_q;
    last_d       = last_q;
    addr_d       = addr_q;
    count_d      = count_q;
    cursor_d     = cursor_q;
    len_d        = len_q;
    bad_d        = bad_q;
    walk_node_d  = walk_node_q;
    walk_valid_d = walk_valid_q;
    pos_d        = pos_q;
    best_d       = best_q;
    hit_d        = hit_q;
    slot_d       = slot_q;
    pend_d       = pend_q;
    rdv_d        = rdv_q;
    pslot_d      = pslot_q;
    kind_d       = kind_q;
    answer_d     = answer_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = addr_q;
    mem_wdata    = '0;
    fin_bad      = bad_q;
    ins_nxt      = cursor_q;

    unique case (state_q)
      S_CLEAR: begin
        // sweep zeros through the child table
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
      S_IDLE: begin
        if (cmd_i.start) begin
          letter_d = cmd_i.letter;
          last_d   = cmd_i.last;
          pend_d   = 1'b0;
          hit_d    = 1'b0;
          slot_d   = SW'(MAX_WORD - 1);
          state_d  = (cmd_i.op == twb_pkg::OP_TEXT) ? S_QRUN : S_DISS;
        end
      end
      S_DISS: begin
        // check the word state, then issue the child read
        if (bad_q == twb_pkg::BAD_NONE && len_q < LENW'(MAX_WORD)) begin
          mem_re  = 1'b1;
          addr_d  = rd_addr;
          state_d = S_DWR;
        end else begin
          if (bad_q == twb_pkg::BAD_NONE) begin
            fin_bad = twb_pkg::BAD_LONG;
          end
          bad_d = fin_bad;
          if (last_q) begin
            kind_d   = (fin_bad == twb_pkg::BAD_FULL) ? twb_pkg::KIND_FULL
                                                      : twb_pkg::KIND_LONG;
            answer_d = '0;
            cursor_d = '0;
            len_d    = '0;
            bad_d    = twb_pkg::BAD_NONE;
            state_d  = S_OUT;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_DWR: begin
        // follow or create the child, mark the word end on the last letter
        fin_bad = twb_pkg::BAD_NONE;
        ins_nxt = child;
        if (child == '0) begin
          if (count_q < CW'(TRIE_NODES)) begin
            ins_nxt   = NW'(count_q);
            count_d   = count_q + CW'(1);
            mem_we    = 1'b1;
            mem_wdata = {last_q, NW'(count_q)};
          end else begin
            fin_bad = twb_pkg::BAD_FULL;
          end
        end else if (last_q) begin
          mem_we    = 1'b1;
          mem_wdata = {1'b1, child};
        end
        bad_d = fin_bad;
        if (fin_bad == twb_pkg::BAD_NONE) begin
          cursor_d = ins_nxt;
          len_d    = len_q + LENW'(1);
        end
        if (last_q) begin
          kind_d   = (fin_bad == twb_pkg::BAD_NONE) ? twb_pkg::KIND_STORED
                                                    : twb_pkg::KIND_FULL;
          answer_d = '0;
          cursor_d = '0;
          len_d    = '0;
          bad_d    = twb_pkg::BAD_NONE;
          state_d  = S_OUT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_QRUN: begin
        // advance the previous slot, read the current one
        hit_d = hit_now;
        if (pend_q && nx_ok) begin
          walk_valid_d[nx_slot] = rdv_q && (child != '0);
          walk_node_d[nx_slot]  = child;
        end
        mem_re  = walk_valid_q[slot_q];
        rdv_d   = walk_valid_q[slot_q];
        pslot_d = slot_q;
        pend_d  = 1'b1;
        if (slot_q == '0) begin
          state_d = S_QLAST;
        end else begin
          slot_d = slot_q - SW'(1);
        end
      end
      S_QLAST: begin
        // finish slot zero, reopen the root walk on a word end
        hit_d = hit_now;
        pend_d = 1'b0;
        if (nx_ok) begin
          walk_valid_d[nx_slot] = rdv_q && (child != '0);
          walk_node_d[nx_slot]  = child;
        end
        walk_valid_d[0] = hit_now;
        walk_node_d[0]  = '0;
        pos_d  = pos_inc;
        best_d = hit_now ? pos_inc : best_q;
        if (last_q) begin
          kind_d       = twb_pkg::KIND_ANSWER;
          answer_d     = twb_pkg::ANSWER_W'(best_d);
          walk_valid_d = MAX_WORD'(1);
          for (int k = 0; k < MAX_WORD; k++) begin
            walk_node_d[k] = '0;
          end
          pos_d   = '0;
          best_d  = '0;
          state_d = S_OUT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_OUT: begin
        if (cmd_i.res_ready) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control and progress registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      count_q      <= CW'(1);
      cursor_q     <= '0;
      len_q        <= '0;
      bad_q        <= twb_pkg::BAD_NONE;
      walk_valid_q <= MAX_WORD'(1);
      pos_q        <= '0;
      best_q       <= '0;
      hit_q        <= 1'b0;
      slot_q       <= '0;
      pend_q       <= 1'b0;
      rdv_q        <= 1'b0;
      pslot_q      <= '0;
      for (int k = 0; k < MAX_WORD; k++) begin
        walk_node_q[k] <= '0;
      end
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      count_q      <= count_d;
      cursor_q     <= cursor_d;
      len_q        <= len_d;
      bad_q        <= bad_d;
      walk_valid_q <= walk_valid_d;
      pos_q        <= pos_d;
      best_q       <= best_d;
      hit_q        <= hit_d;
      slot_q       <= slot_d;
      pend_q       <= pend_d;
      rdv_q        <= rdv_d;
      pslot_q      <= pslot_d;
      walk_node_q  <= walk_node_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    letter_q <= letter_d;
    last_q   <= last_d;
    addr_q   <= addr_d;
    kind_q   <= kind_d;
    answer_q <= answer_d;
  end

  assign stat_o.ready     = (state_q == S_IDLE);
  assign stat_o.res_valid = (state_q == S_OUT);
  assign stat_o.kind      = kind_q;
  assign stat_o.answer    = answer_q;

  `TWB_ASSERT(a_node_count_bound, count_q <= CW'(TRIE_NODES))
  `TWB_ASSERT(a_len_bound, len_q <= LENW'(MAX_WORD))
  `TWB_ASSERT(a_write_follows_read, state_q == S_DWR |-> $past(state_q) == S_DISS)
  `TWB_ASSERT_NEVER(a_letter_clamped, state_q == S_QRUN && 9'(letter_q) >= 9'(ALPHABET))
endmodule

// File: sv/trie_word_break_prefix_core.sv
// Top level of the trie word-break core: input capture, letter clamp, result register.
//
// Usage: one input channel carries letters. operation 0 feeds dictionary word
// letters, operation 1 feeds query text letters; last marks the end of a word
// or of a text. Both kinds may be mixed freely. The output channel carries one
// result per word (kind stored, dropped full, dropped too long) and one per
// text (kind answer, with the longest prefix that splits into stored words).
// A word letter takes one child-table read and, where it creates a child or marks
// a word end, one write back; a letter of a word that is already dropped skips both.
// A text letter steps through every walk slot, one slot per cycle; each valid slot
// issues one read through the single read port of the child-table memory.
// A letter that ends an item then waits in a hand-over state until the result is taken.
// After reset the TRIE_NODES * ALPHABET child-table entries (13312 at the default
// size) are swept to zero; no letter is taken during the sweep.
// When the receiver stalls, one result waits in the output register while the
// next letter is taken; the core then holds its following result until the
// register frees up.
`timescale 1ns / 1ps
module trie_word_break_prefix_core #(
  parameter int TRIE_NODES = 512,
  parameter int MAX_WORD   = 16,
  parameter int ALPHABET   = 26,
  parameter int POS_BITS   = 21
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  twb_in_if.sink     in_i,
  twb_out_if.source  out_o
);
  twb_pkg::twb_cmd_t  cmd;
  twb_pkg::twb_stat_t stat;

  logic                         out_valid_q;
  logic [twb_pkg::KIND_W-1:0]   out_kind_q;
  logic [twb_pkg::ANSWER_W-1:0] out_answer_q;
  logic                         res_ready;
  logic [twb_pkg::LETTER_W-1:0] letter_c;

  // clamp letters past the alphabet to its last letter
  assign letter_c = (9'(in_i.letter) >= 9'(ALPHABET)) ? twb_pkg::LETTER_W'(ALPHABET - 1)
                                                      : in_i.letter;

  assign res_ready     = !out_valid_q || out_o.ready;
  assign in_i.ready    = stat.ready;
  assign cmd.start     = in_i.valid && stat.ready;
  assign cmd.op        = in_i.operation;
  assign cmd.letter    = letter_c;
  assign cmd.last      = in_i.last;
  assign cmd.res_ready = res_ready;

  twb_seq #(
    .TRIE_NODES (TRIE_NODES),
    .MAX_WORD   (MAX_WORD),
    .ALPHABET   (ALPHABET),
    .POS_BITS   (POS_BITS)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

  // hold the result until the output transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= stat.res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && stat.res_valid) begin
      out_kind_q   <= stat.kind;
      out_answer_q <= stat.answer;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.kind   = out_kind_q;
  assign out_o.answer = out_answer_q;
endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for the trie word-break core: random letter traffic, scored results.
`timescale 1ns / 1ps
module tb;
  localparam int NODES = 512;
  localparam int DEPTH = 16;
  localparam int ABC = 26;
  localparam int POS_MAX = (1 << 21) - 1;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic op;
    logic [twb_pkg::LETTER_W-1:0] letter;
    logic last;
  } letter_t;

  typedef struct packed {
    logic [twb_pkg::KIND_W-1:0] kind;
    logic [twb_pkg::ANSWER_W-1:0] answer;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  twb_in_if in_ch();
  twb_out_if out_ch();

  trie_word_break_prefix_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .out_o(out_ch.source)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state
  int unsigned trie_child[NODES*ABC];
  bit trie_term[NODES];
  int unsigned trie_used;
  int unsigned ins_node, ins_len;
  logic [1:0] ins_fault;
  int unsigned walk_at[DEPTH];
  bit walk_on[DEPTH];
  int unsigned txt_pos, txt_best;

  letter_t pending_q[$];
  result_t expected_q[$];
  int errors = 0;
  int results_seen = 0;
  int answers_seen = 0;
  int drops_seen = 0;
  longint cycles = 0;

  task automatic report(input string msg);
    $display("tb: mismatch: %s", msg);
    errors++;
  endtask

  task automatic clear_walks();
    for (int k = 0; k < DEPTH; k++) begin
      walk_at[k] = 0;
      walk_on[k] = 1'b0;
    end
    walk_on[0] = 1'b1;
    txt_pos = 0;
    txt_best = 0;
  endtask

  // Advance the predicted trie/walk state by one accepted letter
  task automatic predict_letter(input letter_t it);
    int unsigned l, idx, nxt, ch;
    int unsigned nn[DEPTH];
    bit nv[DEPTH];
    bit hit;
    result_t r;
    l = (it.letter >= ABC) ? ABC - 1 : 32'(it.letter);
    if (it.op == twb_pkg::OP_WORD) begin
      if (ins_fault == twb_pkg::BAD_NONE) begin
        if (ins_len >= DEPTH) begin
          ins_fault = twb_pkg::BAD_LONG;
        end else begin
          idx = ins_node * ABC + l;
          nxt = trie_child[idx];
          if (nxt == 0) begin
            if (trie_used < NODES) begin
              nxt = trie_used;
              trie_child[idx] = nxt;
              trie_used++;
            end else begin
              ins_fault = twb_pkg::BAD_FULL;
            end
          end
          if (ins_fault == twb_pkg::BAD_NONE) begin
            ins_node = nxt;
            ins_len++;
          end
        end
      end
      if (it.last) begin
        if (ins_fault == twb_pkg::BAD_NONE) begin
          trie_term[ins_node] = 1'b1;
          r.kind = twb_pkg::KIND_STORED;
        end else if (ins_fault == twb_pkg::BAD_FULL) begin
          r.kind = twb_pkg::KIND_FULL;
        end else begin
          r.kind = twb_pkg::KIND_LONG;
        end
        r.answer = '0;
        expected_q.push_back(r);
        ins_node = 0;
        ins_len = 0;
        ins_fault = twb_pkg::BAD_NONE;
      end
    end else begin
      hit = 1'b0;
      for (int k = 0; k < DEPTH; k++) begin
        nn[k] = 0;
        nv[k] = 1'b0;
      end
      for (int k = 0; k < DEPTH; k++) begin
        if (walk_on[k]) begin
          ch = trie_child[walk_at[k] * ABC + l];
          if (ch != 0) begin
            if (trie_term[ch]) hit = 1'b1;
            if (k + 1 < DEPTH) begin
              nv[k+1] = 1'b1;
              nn[k+1] = ch;
            end
          end
        end
      end
      nv[0] = hit;
      for (int k = 0; k < DEPTH; k++) begin
        walk_at[k] = nn[k];
        walk_on[k] = nv[k];
      end
      if (txt_pos < POS_MAX) txt_pos++;
      if (hit) txt_best = txt_pos;
      if (it.last) begin
        r.kind = twb_pkg::KIND_ANSWER;
        r.answer = txt_best[twb_pkg::ANSWER_W-1:0];
        expected_q.push_back(r);
        clear_walks();
      end
    end
  endtask

  // Source driver: hold each letter until its transfer, then idle a random gap
  int src_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        predict_letter(letter_t'({in_ch.operation, in_ch.letter, in_ch.last}));
        void'(pending_q.pop_front());
        src_gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19));
        if ($urandom_range(0, 1) == 0) src_gap = 0;
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (src_gap > 0 || pending_q.size() == 0) begin
          in_ch.valid <= 1'b0;
          if (src_gap > 0) src_gap--;
        end else begin
          in_ch.valid <= 1'b1;
          in_ch.operation <= pending_q[0].op;
          in_ch.letter <= pending_q[0].letter;
          in_ch.last <= pending_q[0].last;
        end
      end
    end
  end

  // Result monitor: score each transfer, then stall ready for a random spell
  int snk_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycles++;
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          report($sformatf("unexpected result kind %0d answer %0d",
                           out_ch.kind, out_ch.answer));
        end else begin
          if (out_ch.kind != expected_q[0].kind)
            report($sformatf("kind %0d, want %0d", out_ch.kind, expected_q[0].kind));
          if (out_ch.answer != expected_q[0].answer)
            report($sformatf("answer %0d, want %0d", out_ch.answer,
                             expected_q[0].answer));
          if (expected_q[0].kind == twb_pkg::KIND_ANSWER) answers_seen++;
          if (expected_q[0].kind == twb_pkg::KIND_FULL ||
              expected_q[0].kind == twb_pkg::KIND_LONG)
            drops_seen++;
          void'(expected_q.pop_front());
        end
        snk_gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 19);
      end
      if (snk_gap > 0) begin
        out_ch.ready <= 1'b0;
        snk_gap--;
      end else begin
        out_ch.ready <= 1'b1;
      end
      if (cycles > CYCLE_LIMIT) begin
        $display("tb: timeout after %0d cycles", cycles);
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  // Queue one word or text; letters past z exercise the clamp
  task automatic push_seq(input logic op, input int unsigned len, input int unsigned alpha);
    letter_t it;
    for (int unsigned i = 0; i < len; i++) begin
      it.op = op;
      it.letter = twb_pkg::LETTER_W'($urandom_range(0, alpha - 1));
      if ($urandom_range(0, 60) == 0) it.letter = twb_pkg::LETTER_W'($urandom_range(ABC, 31));
      it.last = (i == len - 1);
      pending_q.push_back(it);
    end
  endtask

  task automatic push_letter(input logic op, input int unsigned l, input logic last);
    letter_t it;
    it.op = op;
    it.letter = twb_pkg::LETTER_W'(l);
    it.last = last;
    pending_q.push_back(it);
  endtask

  task automatic wait_drain();
    while (pending_q.size() != 0 || expected_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned total;
    in_ch.valid = 1'b0;
    in_ch.operation = twb_pkg::OP_WORD;
    in_ch.letter = '0;
    in_ch.last = 1'b0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < NODES*ABC; i++) trie_child[i] = 0;
    for (int i = 0; i < NODES; i++) trie_term[i] = 1'b0;
    trie_used = 1;
    ins_node = 0;
    ins_len = 0;
    ins_fault = twb_pkg::BAD_NONE;
    clear_walks();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: texts on an empty trie, short words, duplicates, clamp, long words
    push_letter(twb_pkg::OP_TEXT, 0, 1'b1);
    push_letter(twb_pkg::OP_WORD, 0, 1'b1);             // "a"
    push_letter(twb_pkg::OP_WORD, 25, 1'b0);
    push_letter(twb_pkg::OP_WORD, 31, 1'b1);            // "zz" via clamp
    push_letter(twb_pkg::OP_WORD, 0, 1'b1);             // duplicate
    push_letter(twb_pkg::OP_TEXT, 0, 1'b0);
    push_letter(twb_pkg::OP_TEXT, 25, 1'b0);
    push_letter(twb_pkg::OP_TEXT, 26, 1'b0);
    push_letter(twb_pkg::OP_TEXT, 1, 1'b1);             // "azzb" -> 3
    push_seq(twb_pkg::OP_WORD, 16, 2);                  // exactly the depth limit
    push_seq(twb_pkg::OP_WORD, 17, 26);                 // one over, dropped
    push_letter(twb_pkg::OP_TEXT, 0, 1'b0);
    push_letter(twb_pkg::OP_WORD, 25, 1'b1);            // "z" added mid-text
    push_letter(twb_pkg::OP_TEXT, 25, 1'b1);
    total = pending_q.size();
    wait_drain();

    // Random: mostly texts, over a small alphabet (as are most words) so texts segment deeply
    while (total < 550) begin
      int unsigned len;
      if ($urandom_range(0, 2) == 0) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 5);
        push_seq(twb_pkg::OP_WORD, len, $urandom_range(0, 3) == 0 ? 26 : 3);
      end else begin
        len = $urandom_range(1, 30);
        push_seq(twb_pkg::OP_TEXT, len, 3);
      end
      total += len;
    end
    wait_drain();

    // Fill the trie with 42 long random words so that drops for a full trie show up
    for (int i = 0; i < 42; i++) push_seq(twb_pkg::OP_WORD, 14, 26);
    push_seq(twb_pkg::OP_TEXT, 20, 26);
    push_seq(twb_pkg::OP_WORD, 18, 26);
    wait_drain();
    repeat (200) @(posedge clk_i);

    $display("tb: %0d results checked, %0d text answers, %0d dropped words, %0d nodes used",
             results_seen, answers_seen, drops_seen, trie_used);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
